FILE: hw/rtl/rbf_pkg.sv
// Shared types, sizes and helpers of the RGB 3x3 box filter.
package rbf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = COL_W + 1;
  localparam int HGT_W = ROW_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HGT_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

  // nine 8-bit values
  localparam int SUM_W = 12;

  // floor(s / 9) == (s * 7282) >> 16 for every sum of nine bytes
  localparam int                 RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP  = RECIP_W'(7282);
  localparam int                 RECIP_SHIFT = 16;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       red_mean;
    logic [7:0]       green_mean;
    logic [7:0]       blue_mean;
    logic [ROW_W-1:0] centre_row;
    logic [COL_W-1:0] centre_col;
    logic             frame_end;
  } result_t;

  // one column of both line stores: row r-2 above, row r-1 below
  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } line_pair_t;

  typedef struct packed {
    pixel_t           top_px;
    pixel_t           mid_px;
    pixel_t           cur_px;
    logic [ROW_W-1:0] centre_row;
    logic [COL_W-1:0] centre_col;
    logic             produce;
    logic             frame_end;
  } q_entry_t;

  function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+RECIP_W-1:0] p;
    p = (SUM_W + RECIP_W)'(s) * (SUM_W + RECIP_W)'(DIV9_RECIP);
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage

FILE: hw/rtl/rbf_front.sv
// Front end: frame counters, configuration registers and the line stores.
module rbf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rbf_pkg::pixel_t                  in_data,
  output logic                             push,
  output rbf_pkg::q_entry_t                push_entry,
  input  logic                             q_full
);

  logic [rbf_pkg::WID_W-1:0] width_r, width_nxt, w_eff;
  logic [rbf_pkg::HGT_W-1:0] height_r, height_nxt, h_eff;
  logic                      cfg_hit;
  logic [rbf_pkg::COL_W-1:0] col_r, col_nxt;
  logic [rbf_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      last_col, last_row, in_accept;

  logic                      s1_v_r, s1_v_nxt;
  rbf_pkg::pixel_t           s1_cur_r;
  logic [rbf_pkg::COL_W-1:0] s1_col_r;
  logic [rbf_pkg::ROW_W-1:0] s1_crow_r;
  logic [rbf_pkg::COL_W-1:0] s1_ccol_r;
  logic                      s1_prod_r, s1_end_r;
  rbf_pkg::line_pair_t       rd_r;
  rbf_pkg::line_pair_t       line_mem [rbf_pkg::MAX_WIDTH];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    cfg_hit    = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        rbf_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = cfg_data[rbf_pkg::WID_W-1:0];
          cfg_hit   = 1'b1;
        end
        rbf_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = cfg_data;
          cfg_hit    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (width_r == '0) begin
      w_eff = rbf_pkg::WID_W'(1);
    end else if (width_r > rbf_pkg::WID_W'(rbf_pkg::MAX_WIDTH)) begin
      w_eff = rbf_pkg::WID_W'(rbf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = rbf_pkg::HGT_W'(1);
    end else if (height_r > rbf_pkg::HGT_W'(rbf_pkg::MAX_HEIGHT)) begin
      h_eff = rbf_pkg::HGT_W'(rbf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign in_stall  = s1_v_r && q_full;
  assign in_accept = in_valid && !in_stall;
  assign push      = s1_v_r && !q_full;
  assign last_col  = ({1'b0, col_r} + rbf_pkg::WID_W'(1)) == w_eff;
  assign last_row  = ({1'b0, row_r} + rbf_pkg::HGT_W'(1)) == h_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + rbf_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + rbf_pkg::COL_W'(1);
      end
    end
  end

  always_comb begin
    if (in_accept) begin
      s1_v_nxt = 1'b1;
    end else if (push) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rbf_pkg::WIDTH_RESET;
      height_r <= rbf_pkg::HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_v_r   <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cur_r  <= in_data;
      s1_col_r  <= col_r;
      s1_crow_r <= row_r - rbf_pkg::ROW_W'(1);
      s1_ccol_r <= col_r - rbf_pkg::COL_W'(1);
      s1_prod_r <= (row_r >= rbf_pkg::ROW_W'(2)) && (col_r >= rbf_pkg::COL_W'(2));
      s1_end_r  <= last_col && last_row;
    end
  end

  // read on accept, write back the shifted column when the request leaves
  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[s1_col_r] <= '{upper: rd_r.lower, lower: s1_cur_r};
    end
    if (in_accept) begin
      rd_r <= line_mem[col_r];
    end
  end

  always_comb begin
    push_entry.top_px     = rd_r.upper;
    push_entry.mid_px     = rd_r.lower;
    push_entry.cur_px     = s1_cur_r;
    push_entry.centre_row = s1_crow_r;
    push_entry.centre_col = s1_ccol_r;
    push_entry.produce    = s1_prod_r;
    push_entry.frame_end  = s1_end_r;
  end

endmodule

FILE: hw/rtl/rbf_queue.sv
// Short request queue between the front end and the filter back end.
module rbf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rbf_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output rbf_pkg::q_entry_t head
);

  rbf_pkg::q_entry_t           slots [rbf_pkg::Q_DEPTH];
  logic [rbf_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [rbf_pkg::Q_PTR_W:0]   count_r, count_nxt;

  assign full       = count_r == (rbf_pkg::Q_PTR_W + 1)'(rbf_pkg::Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + rbf_pkg::Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + rbf_pkg::Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (rbf_pkg::Q_PTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (rbf_pkg::Q_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: hw/rtl/rbf_back.sv
// Back end: 3x3 window, per-channel sums, divide by nine and output register.
module rbf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  rbf_pkg::q_entry_t head,
  output logic              pop,
  output logic              out_valid,
  output rbf_pkg::result_t  out_data,
  input  logic              out_stall
);

  rbf_pkg::pixel_t           col_px  [3];
  rbf_pkg::pixel_t           win1_r  [3];
  rbf_pkg::pixel_t           win2_r  [3];
  logic [rbf_pkg::SUM_W-1:0] sum_red, sum_green, sum_blue;

  logic                      sum_v_r, sum_v_nxt, sum_go;
  logic [rbf_pkg::SUM_W-1:0] sum_red_r, sum_green_r, sum_blue_r;
  logic [rbf_pkg::ROW_W-1:0] sum_row_r;
  logic [rbf_pkg::COL_W-1:0] sum_col_r;
  logic                      sum_end_r;

  logic                      out_v_r, out_v_nxt;
  rbf_pkg::result_t          out_r;

  assign col_px[0] = head.top_px;
  assign col_px[1] = head.mid_px;
  assign col_px[2] = head.cur_px;

  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int i = 0; i < 3; i++) begin
      sum_red   = sum_red + rbf_pkg::SUM_W'(col_px[i].red_in)
                + rbf_pkg::SUM_W'(win1_r[i].red_in) + rbf_pkg::SUM_W'(win2_r[i].red_in);
      sum_green = sum_green + rbf_pkg::SUM_W'(col_px[i].green_in)
                + rbf_pkg::SUM_W'(win1_r[i].green_in) + rbf_pkg::SUM_W'(win2_r[i].green_in);
      sum_blue  = sum_blue + rbf_pkg::SUM_W'(col_px[i].blue_in)
                + rbf_pkg::SUM_W'(win1_r[i].blue_in) + rbf_pkg::SUM_W'(win2_r[i].blue_in);
    end
  end

  assign sum_go = sum_v_r && (!out_v_r || !out_stall);
  // every request shifts the window, so pop even when it yields no result
  assign pop    = head_valid && (!sum_v_r || sum_go);

  always_comb begin
    if (pop) begin
      sum_v_nxt = head.produce;
    end else if (sum_go) begin
      sum_v_nxt = 1'b0;
    end else begin
      sum_v_nxt = sum_v_r;
    end
    if (sum_go) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      sum_v_r <= sum_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 3; i++) begin
        win2_r[i] <= win1_r[i];
        win1_r[i] <= col_px[i];
      end
    end
    if (pop && head.produce) begin
      sum_red_r   <= sum_red;
      sum_green_r <= sum_green;
      sum_blue_r  <= sum_blue;
      sum_row_r   <= head.centre_row;
      sum_col_r   <= head.centre_col;
      sum_end_r   <= head.frame_end;
    end
    if (sum_go) begin
      out_r.red_mean   <= rbf_pkg::div9(sum_red_r);
      out_r.green_mean <= rbf_pkg::div9(sum_green_r);
      out_r.blue_mean  <= rbf_pkg::div9(sum_blue_r);
      out_r.centre_row <= sum_row_r;
      out_r.centre_col <= sum_col_r;
      out_r.frame_end  <= sum_end_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/rgb_box_filter_3x3_top.sv
// Top level of the streaming RGB 3x3 box filter.
//
// Pixels enter in raster order on in_valid/in_stall, one request per pixel.
// Every interior pixel of the frame gives one result on out_valid/out_stall:
// the truncated mean of its nine neighbours per channel, its row and column,
// and frame_end on the last result of the frame. Border pixels give none.
// cfg_index 0 sets the width, 1 the height; a write restarts the frame and
// cfg_ready is always high. Write only while the filter is idle.
// Throughput: one pixel per cycle while in_stall is low, set by the single
// line store read and write back of each pixel column. A result goes from
// the front stage via the queue and sum register to the output register.
// Reset: 640 x 480 frame, counters at the frame start, queue and output
// empty; line store contents are undefined but never reach a result, as
// each frame fills its rows before they are used.
// A stalled result holds; the 4-entry queue and front stage then fill and
// in_stall rises.
module rgb_box_filter_3x3_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rbf_pkg::pixel_t                in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rbf_pkg::result_t               out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              push, q_full, pop, head_valid;
  rbf_pkg::q_entry_t push_entry, head;

  assign cfg_ready = 1'b1;

  rbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_entry(push_entry),
    .q_full    (q_full)
  );

  rbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  rbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

FILE: hw/rtl/rbf_checker.sv
// Port-level checks of the box filter, bound to the top level.
module rbf_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input rbf_pkg::result_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("filter not idle after reset");

  // input back-pressure only comes from a result held by the receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_stall))
    else $error("input stalled without a held result");

endmodule

bind rgb_box_filter_3x3_top rbf_checker u_rbf_checker (.*);
